### rtl/core/plsq_pkg.sv
// ----------------------------------------------------------------------------
// plsq_pkg: shared definitions for the positional list, stack and queue
// Sizes, operation codes and the structs that pass between the sequencer,
// the entry store and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package plsq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned KIND_W = 4;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND      = 4'd0,
    K_INSERT_AT   = 4'd1,
    K_DELETE_LAST = 4'd2,
    K_DELETE_AT   = 4'd3,
    K_READ_AT     = 4'd4,
    K_PUSH        = 4'd5,
    K_POP         = 4'd6,
    K_ENQUEUE     = 4'd7,
    K_DEQUEUE     = 4'd8
  } kind_e;

  // Access request from the sequencer to the entry store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;
  } mem_req_t;

  // Result state from the sequencer to the top level.
  typedef struct packed {
    logic              done;
    logic              status;
    logic              rvalid;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] front;
    logic [WORD_W-1:0] back;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/positional_list_stack_queue.sv
// ----------------------------------------------------------------------------
// positional_list_stack_queue: bounded list with stack and queue operations
// Ordered store of up to DEPTH words with positional insert, delete and read,
// stack push and pop, and queue enqueue and dequeue.
// ----------------------------------------------------------------------------
// Sequence: a read or a refused operation goes through fetch, peek and done;
//   an insert or delete first walks each moved entry (read, then write).
// Busy stays high until the result cycle ends, so a new operation is taken
//   only after the last one's result; entries move one at a time through the
//   single write port. Results cannot be stalled by the receiver.
// Reset: count and queue flag clear at once, the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_stack_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [plsq_pkg::KIND_W-1:0] kind_i,
  input  wire logic [plsq_pkg::POS_W-1:0]  position_i,
  input  wire logic [plsq_pkg::WORD_W-1:0] value_i,
  output logic                             done_o,
  output logic                             status_o,
  output logic [plsq_pkg::WORD_W-1:0]      read_value_o,
  output logic                             read_valid_o,
  output logic [plsq_pkg::CNT_W-1:0]       count_o,
  output logic [plsq_pkg::WORD_W-1:0]      front_value_o,
  output logic [plsq_pkg::WORD_W-1:0]      back_value_o,
  output logic                             is_empty_o
);
  import plsq_pkg::*;

  mem_req_t          req;
  rsp_t              rsp;
  logic [WORD_W-1:0] rdata0;
  logic [WORD_W-1:0] rdata1;
  logic              empty;

  // The sequencer owns all control state: count, queue flag and the cursor
  // that walks entries across during an insert or delete.
  plsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_i    (value_i),
    .rdata0_i   (rdata0),
    .rdata1_i   (rdata1),
    .req_o      (req),
    .rsp_o      (rsp)
  );

  // Entries below the count are always written before they are read, so the
  // store itself carries no reset.
  plsq_store u_store (
    .clk_i    (clk_i),
    .req_i    (req),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // In the result cycle the first read port holds the word at the requested
  // position; it is shown only when that position was inside the list.
  assign empty         = (rsp.count == '0);
  assign done_o        = rsp.done;
  assign status_o      = rsp.status;
  assign read_valid_o  = rsp.rvalid;
  assign read_value_o  = rsp.rvalid ? rdata0 : '0;
  assign count_o       = rsp.count;
  assign front_value_o = empty ? '0 : rsp.front;
  assign back_value_o  = empty ? '0 : rsp.back;
  assign is_empty_o    = empty;

  // The result strobe only appears while the block reports busy.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy phase");

  // After the result the block is ready for the next transfer.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after its result");

  // An accepted transfer always starts work.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= CNT_W'(DEPTH))
    else $error("entry count out of bounds");

  // The count only changes while an operation is in progress.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> ($stable(count_o) || busy))
    else $error("entry count changed while idle");

endmodule

`default_nettype wire

### rtl/core/plsq_store.sv
// ----------------------------------------------------------------------------
// plsq_store: entry store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plsq_store (
  input  wire logic                      clk_i,
  input  wire plsq_pkg::mem_req_t        req_i,
  output logic [plsq_pkg::WORD_W-1:0]    rdata0_o,
  output logic [plsq_pkg::WORD_W-1:0]    rdata1_o
);
  import plsq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata0_q;
  logic [WORD_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata0_q <= mem[req_i.raddr0];
    rdata1_q <= mem[req_i.raddr1];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

### rtl/core/plsq_ctrl.sv
// ----------------------------------------------------------------------------
// plsq_ctrl: operation sequencer
// Decodes an operation, moves entries one at a time through the store's
// single write port, keeps count and queue flag, and fetches the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module plsq_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [plsq_pkg::KIND_W-1:0] kind_i,
  input  wire logic [plsq_pkg::POS_W-1:0]  position_i,
  input  wire logic [plsq_pkg::WORD_W-1:0] value_i,
  input  wire logic [plsq_pkg::WORD_W-1:0] rdata0_i,
  input  wire logic [plsq_pkg::WORD_W-1:0] rdata1_i,
  output plsq_pkg::mem_req_t             req_o,
  output plsq_pkg::rsp_t                 rsp_o
);
  import plsq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_WRITE,
    S_FETCH,
    S_PEEK,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [ADDR_W-1:0] end_q, end_d;
  logic              ins_q, ins_d;
  logic [WORD_W-1:0] value_q, value_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              ok_q, ok_d;
  logic              rvalid_q, rvalid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              lock_q, lock_d;
  logic [WORD_W-1:0] front_q, front_d;
  logic [WORD_W-1:0] back_q, back_d;
  mem_req_t          req;

  always_comb begin
    logic              full;
    logic              empty;
    logic              in_range;
    logic              do_ins;
    logic              do_rem;
    logic [ADDR_W-1:0] at_a;
    logic [ADDR_W-1:0] end_a;
    logic [ADDR_W-1:0] last_a;

    full     = (cnt_q == CNT_W'(DEPTH));
    empty    = (cnt_q == '0);
    in_range = (position_i < POS_W'(cnt_q));
    end_a    = cnt_q[ADDR_W-1:0];
    last_a   = ADDR_W'(cnt_q - 1'b1);
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    at_a     = end_a;

    state_d  = state_q;
    cur_d    = cur_q;
    end_d    = end_q;
    ins_d    = ins_q;
    value_d  = value_q;
    pos_d    = pos_q;
    ok_d     = ok_q;
    rvalid_d = rvalid_q;
    cnt_d    = cnt_q;
    lock_d   = lock_q;
    front_d  = front_q;
    back_d   = back_q;
    req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ok_d     = 1'b0;
          rvalid_d = 1'b0;
          value_d  = value_i;
          pos_d    = position_i[ADDR_W-1:0];
          unique case (kind_e'(kind_i))
            K_APPEND: begin
              do_ins = !lock_q && !full;
              at_a   = end_a;
            end
            K_INSERT_AT: begin
              do_ins = !lock_q && !full;
              at_a   = in_range ? position_i[ADDR_W-1:0] : end_a;
            end
            K_DELETE_LAST: begin
              do_rem = !lock_q && !empty;
              at_a   = last_a;
            end
            K_DELETE_AT: begin
              if (in_range) begin
                do_rem = 1'b1;
                at_a   = position_i[ADDR_W-1:0];
              end else begin
                do_rem = !lock_q && !empty;
                at_a   = last_a;
              end
            end
            K_READ_AT: begin
              ok_d     = 1'b1;
              rvalid_d = in_range;
            end
            K_PUSH: begin
              do_ins = !full;
              at_a   = end_a;
            end
            K_POP: begin
              do_rem = !empty;
              at_a   = last_a;
            end
            K_ENQUEUE: begin
              if (!empty && !full) begin
                lock_d = 1'b1;
              end
              do_ins = !full;
              at_a   = end_a;
            end
            K_DEQUEUE: begin
              do_rem = !empty;
              at_a   = '0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
          if (do_ins) begin
            // Walk from the end slot down to the insert slot.
            ok_d    = 1'b1;
            ins_d   = 1'b1;
            cur_d   = end_a;
            end_d   = at_a;
            state_d = S_MOVE;
          end else if (do_rem) begin
            // Walk from the removed slot up to the last slot.
            ok_d    = 1'b1;
            ins_d   = 1'b0;
            cur_d   = at_a;
            end_d   = last_a;
            state_d = S_MOVE;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_MOVE: begin
        if (cur_q == end_q) begin
          if (ins_q) begin
            req.we    = 1'b1;
            req.waddr = cur_q;
            req.wdata = value_q;
            cnt_d     = cnt_q + 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
          state_d = S_FETCH;
        end else begin
          req.raddr0 = ins_q ? (cur_q - 1'b1) : (cur_q + 1'b1);
          state_d    = S_WRITE;
        end
      end
      S_WRITE: begin
        req.we    = 1'b1;
        req.waddr = cur_q;
        req.wdata = rdata0_i;
        cur_d     = ins_q ? (cur_q - 1'b1) : (cur_q + 1'b1);
        state_d   = S_MOVE;
      end
      S_FETCH: begin
        req.raddr0 = '0;
        req.raddr1 = last_a;
        state_d    = S_PEEK;
      end
      S_PEEK: begin
        front_d    = rdata0_i;
        back_d     = rdata1_i;
        req.raddr0 = pos_q;
        state_d    = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      lock_q   <= 1'b0;
      ok_q     <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lock_q   <= lock_d;
      ok_q     <= ok_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    end_q   <= end_d;
    ins_q   <= ins_d;
    value_q <= value_d;
    pos_q   <= pos_d;
    front_q <= front_d;
    back_q  <= back_d;
  end

  assign req_o        = req;
  assign busy         = (state_q != S_IDLE);
  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.status = !ok_q;
  assign rsp_o.rvalid = rvalid_q;
  assign rsp_o.count  = cnt_q;
  assign rsp_o.front  = front_q;
  assign rsp_o.back   = back_q;

endmodule

`default_nettype wire
